// ===== hw/rtl/isq_pkg.sv =====
// isq_pkg: shared types for the indexed sequence store.
// Holds command and status codes and the per-cell operation struct.
// No dependencies.
package isq_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_INSERT     = 3'd4,
    CMD_REMOVE     = 3'd5,
    CMD_READ       = 3'd6,
    CMD_WRITE      = 3'd7
  } isq_cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } isq_status_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;  // open a slot at the position, shift tail up
    logic del;  // close the slot at the position, shift tail down
    logic wr;   // overwrite the word at the position
  } isq_op_t;

endpackage

// ===== hw/rtl/isq_if.sv =====
// isq_if: valid/ready channel interfaces for the indexed sequence store.
// Command channel and result channel; depends on nothing.
interface isq_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [3:0]  position;
  logic signed [31:0] value;

  modport source (output valid, cmd, position, value, input ready);
  modport sink   (input valid, cmd, position, value, output ready);
endinterface

interface isq_rsp_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] read_value;
  logic [4:0]  count;
  logic [1:0]  status;

  modport source (output valid, read_value, count, status, input ready);
  modport sink   (input valid, read_value, count, status, output ready);
endinterface

// ===== hw/rtl/isq_cell.sv =====
// isq_cell: one storage cell of the element chain.
// Holds one word and takes its neighbor's word on a shift; uses isq_pkg.
module isq_cell import isq_pkg::*; #(
  parameter int AW    = 5,
  parameter int INDEX = 0
) (
  input  logic                 clk,
  input  isq_op_t              op,
  input  logic [AW-1:0]        pos,
  input  logic signed [31:0]   value,
  input  logic signed [31:0]   left,
  input  logic signed [31:0]   right,
  output logic signed [31:0]   elem
);

  localparam logic [AW-1:0] MyIdx = AW'(INDEX);

  logic signed [31:0] elem_next;

  always_comb begin
    elem_next = elem;
    if (op.ins) begin
      if (MyIdx == pos) begin
        elem_next = value;
      end else if (MyIdx > pos) begin
        elem_next = left;
      end
    end else if (op.del) begin
      if (MyIdx >= pos) begin
        elem_next = right;
      end
    end else if (op.wr) begin
      if (MyIdx == pos) begin
        elem_next = value;
      end
    end
  end

  // Payload only: no reset.
  always_ff @(posedge clk) begin
    elem <= elem_next;
  end

endmodule

// ===== hw/rtl/indexed_sequence_store.sv =====
// indexed_sequence_store: bounded ordered list of signed words in a chain of cells.
// The result of a command transaction is registered and shown in the cycle after it.
// Throughput: one command per cycle while the result channel is ready; every cell shifts in parallel in the same edge.
// A new command is taken while the result register is empty or being drained.
// Reset (synchronous, active high) clears the count and the result valid;
// the cell words stay undefined until written. Uses isq_pkg, isq_if, isq_cell.
module indexed_sequence_store import isq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst,
  isq_cmd_if.sink    command,
  isq_rsp_if.source  result
);

  // Count needs room for CAPACITY itself; positions are compared in AW bits
  // so that a 4-bit position never gets truncated against a small store.
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int AW  = (CW > 4) ? CW : 4;
  // Only the first sixteen cells can be addressed by a position.
  localparam int RDN = (CAPACITY < 16) ? CAPACITY : 16;

  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic               rsp_valid;
  logic signed [31:0] rsp_read_value;
  logic [4:0]         rsp_count;
  isq_status_t        rsp_status;

  logic               fire;
  logic               full;
  logic               in_range;
  logic [AW-1:0]      pos_ext;
  isq_cmd_t           cmd;
  isq_op_t            op;
  logic [AW-1:0]      op_pos;
  isq_status_t        status;
  logic signed [31:0] read_word;
  logic signed [31:0] rd;

  logic signed [31:0] elems [CAPACITY];

  // Take a command whenever the result register is free or empties this cycle.
  assign command.ready = !rsp_valid || result.ready;
  assign fire          = command.valid && command.ready;

  assign cmd      = isq_cmd_t'(command.cmd);
  assign pos_ext  = AW'(command.position);
  assign full     = count >= CW'(CAPACITY);
  assign in_range = pos_ext < AW'(count);

  // Select the addressed word for a read.
  always_comb begin
    read_word = '0;
    for (int i = 0; i < RDN; i++) begin
      if (command.position == 4'(i)) begin
        read_word = elems[i];
      end
    end
  end

  // Decode the command into one broadcast operation, the new count, the status and the read word.
  always_comb begin
    op         = '0;
    op_pos     = '0;
    count_next = count;
    status     = ST_OK;
    rd         = '0;
    case (cmd)
      CMD_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          op.wr      = 1'b1;
          op_pos     = AW'(count);
          count_next = count + CW'(1);
        end
      end
      CMD_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          op.ins     = 1'b1;
          count_next = count + CW'(1);
        end
      end
      CMD_POP_BACK: begin
        if (count != '0) begin
          count_next = count - CW'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (count != '0) begin
          op.del     = 1'b1;
          count_next = count - CW'(1);
        end
      end
      CMD_INSERT: begin
        // Out of range wins over full; an insert never appends.
        if (!in_range) begin
          status = ST_RANGE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          op.ins     = 1'b1;
          op_pos     = pos_ext;
          count_next = count + CW'(1);
        end
      end
      CMD_REMOVE: begin
        if (!in_range) begin
          status = ST_RANGE;
        end else begin
          op.del     = 1'b1;
          op_pos     = pos_ext;
          count_next = count - CW'(1);
        end
      end
      CMD_READ: begin
        if (!in_range) begin
          status = ST_RANGE;
        end else begin
          rd = read_word;
        end
      end
      CMD_WRITE: begin
        if (!in_range) begin
          status = ST_RANGE;
        end else begin
          op.wr  = 1'b1;
          op_pos = pos_ext;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  // Chain of cells: each sees its lower and upper neighbor. The ends see
  // their own word, which only ever lands in slots beyond the count.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [31:0] left;
    logic signed [31:0] right;
    if (g == 0) begin : g_lo
      assign left = elems[g];
    end else begin : g_mid_lo
      assign left = elems[g-1];
    end
    if (g == CAPACITY - 1) begin : g_hi
      assign right = elems[g];
    end else begin : g_mid_hi
      assign right = elems[g+1];
    end
    isq_cell #(
      .AW    (AW),
      .INDEX (g)
    ) u_cell (
      .clk   (clk),
      .op    (fire ? op : isq_op_t'('0)),
      .pos   (op_pos),
      .value (command.value),
      .left  (left),
      .right (right),
      .elem  (elems[g])
    );
  end

  // Count and result valid: control state, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (fire) begin
        count <= count_next;
      end
      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (result.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Hold the result payload until the transaction completes.
  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_read_value <= rd;
      rsp_count      <= 5'(count_next);
      rsp_status     <= status;
    end
  end

  assign result.valid      = rsp_valid;
  assign result.read_value = rsp_read_value;
  assign result.count      = rsp_count;
  assign result.status     = rsp_status;

endmodule
